>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the cycle after the antecedent.
`define PPBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent is checked in the same cycle as the antecedent.
`define PPBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/ppbi_pkg.sv
// ---------------------------------------------------------------------------
// Piecewise polynomial backward integral package
// Beat types, sequencer states, constants and helper functions.
// ---------------------------------------------------------------------------
package ppbi_pkg;

  localparam int unsigned MAX_TERMS   = 4;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COEF_N      = 4;
  localparam int unsigned TERM_LIMIT  = (MAX_TERMS < COEF_N) ? MAX_TERMS : COEF_N;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned DIGIT_W     = 16;
  localparam int unsigned REM_W       = 3;
  localparam int unsigned CUR_W       = DIGIT_W + REM_W;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 21;

  typedef logic [2:0] term_count_t;
  typedef logic [2:0] term_idx_t;
  typedef logic [2:0] divisor_t;

  localparam term_idx_t IDX_SUM  = 3'd0;
  localparam term_idx_t IDX_DIFF = 3'd1;
  localparam term_idx_t IDX_G0   = 3'd2;
  localparam divisor_t  TRAP_DIV = 3'd2;

  typedef struct packed {
    logic               restart;
    logic        [30:0] interval_width;
    logic signed [31:0] f_left;
    logic signed [31:0] f_right;
    logic signed [31:0] coef_0;
    logic signed [31:0] coef_1;
    logic signed [31:0] coef_2;
    logic signed [31:0] coef_3;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] integral_left;
    logic signed [31:0] slot_0;
    logic signed [31:0] slot_1;
    logic signed [31:0] slot_2;
    logic signed [31:0] slot_3;
    logic signed [31:0] slot_4;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN1,
    ST_FIN2
  } state_e;

  typedef struct packed {
    logic     start;
    divisor_t divisor;
  } cdiv_ctrl_t;

  // Reciprocal of the divisor scaled by 2^RECIP_SHIFT, rounded up. It is exact for
  // every partial dividend below the divisor times 2^DIGIT_W.
  function automatic logic [RECIP_W-1:0] recip(input divisor_t d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      3'd3:    m = 21'd699051;
      3'd4:    m = 21'd524288;
      3'd5:    m = 21'd419431;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ppbi_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying the term count register value.
// ---------------------------------------------------------------------------
interface ppbi_cfg_if import ppbi_pkg::*; ();
  logic        valid;
  logic        ready;
  term_count_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ppbi_in_if.sv
// ---------------------------------------------------------------------------
// Interval input channel
// Valid/ready channel carrying one interval beat.
// ---------------------------------------------------------------------------
interface ppbi_in_if import ppbi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ppbi_out_if.sv
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the integral and slot beat.
// ---------------------------------------------------------------------------
interface ppbi_out_if import ppbi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ppbi_cdiv.sv
// ---------------------------------------------------------------------------
// Digit-serial constant divider
// Divides an unsigned value by 2, 3, 4 or 5, one 16-bit digit per cycle,
// using a reciprocal multiply and a small remainder correction.
// ---------------------------------------------------------------------------
module ppbi_cdiv import ppbi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cdiv_ctrl_t                   ctrl_i,
  input  logic [PROD_W-FracBits-1:0]   dividend_i,
  output logic [PROD_W-FracBits-1:0]   quotient_o,
  output logic                         done_o
);

  localparam int unsigned QW    = PROD_W - FracBits;
  localparam int unsigned ND    = (QW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PAD_W = ND * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(ND);

  logic [PAD_W-1:0]          num_q;
  logic [PAD_W-1:0]          quo_q;
  logic [REM_W-1:0]          rem_q;
  divisor_t                  div_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [CUR_W-1:0]          cur;
  logic [CUR_W+RECIP_W-1:0]  est;
  logic [DIGIT_W-1:0]        qd;
  logic [CUR_W-1:0]          back;
  logic [CUR_W-1:0]          rem_full;

  assign cur      = {rem_q, num_q[PAD_W-1 -: DIGIT_W]};
  assign est      = (CUR_W+RECIP_W)'(cur) * (CUR_W+RECIP_W)'(recip(div_q));
  assign qd       = est[RECIP_SHIFT +: DIGIT_W];
  assign back     = CUR_W'(qd) * CUR_W'(div_q);
  assign rem_full = cur - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ND - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q <= PAD_W'(dividend_i);
      rem_q <= '0;
      div_q <= ctrl_i.divisor;
    end else if (busy_q) begin
      num_q <= num_q << DIGIT_W;
      quo_q <= {quo_q[PAD_W-DIGIT_W-1:0], qd};
      rem_q <= rem_full[REM_W-1:0];
    end
  end

  assign quotient_o = quo_q[QW-1:0];
  assign done_o     = done_q;

endmodule

>>> rtl/piecewise_poly_backward_integral_core.sv
// ---------------------------------------------------------------------------
// Piecewise polynomial backward integral core
// Each term passes operand setup, the shared 31x32 multiplier and the
// digit-serial constant divider over ND = ceil((64 - FracBits) / 16) digits.
// An item has 2 + r terms, r the clamped term count. The core is ready for
// the next beat in the same cycle as the item's result turns valid; the result
// waits while an earlier result is stalled at the output.
// Reset clears the running integral, the term count and any pending result.
// ---------------------------------------------------------------------------
module piecewise_poly_backward_integral_core import ppbi_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppbi_cfg_if.sink    cfg_i,
  ppbi_in_if.sink     in_i,
  ppbi_out_if.source  out_o
);

  localparam int unsigned QW = PROD_W - FracBits;

  state_e                    state_q, state_d;
  term_count_t               term_count_q;
  term_idx_t                 r_q;
  term_idx_t                 idx_q;
  logic [30:0]               w_q;
  logic signed [31:0]        fl_q;
  logic signed [31:0]        fr_q;
  logic signed [31:0]        g_q [COEF_N];
  logic signed [31:0]        running_q;
  logic signed [63:0]        acc_int_q;
  logic signed [63:0]        acc_s1_q;
  logic signed [31:0]        slot_q [4];
  logic                      neg_q;
  logic [32:0]               mag_q;
  divisor_t                  d_q;
  logic [PROD_W-1:0]         prod_q;
  out_beat_t                 out_q;
  logic                      out_valid_q;

  logic                      in_acc;
  logic                      out_load;
  logic                      last_term;
  cdiv_ctrl_t                div_ctrl;
  logic [QW-1:0]             quotient;
  logic                      div_done;
  logic signed [32:0]        x_sel;
  logic signed [31:0]        g_sel;
  logic [62:0]               mul_res;
  logic [PROD_W-1:0]         rounded;
  logic signed [63:0]        q_ext;
  logic signed [63:0]        term;
  logic signed [63:0]        slot_sum;
  term_idx_t                 r_new;

  assign in_acc    = in_i.valid && in_i.ready;
  assign last_term = (idx_q == (IDX_DIFF + r_q));
  assign r_new     = (term_count_q > term_count_t'(TERM_LIMIT)) ?
                     term_idx_t'(TERM_LIMIT) : term_count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_OPER;
      ST_OPER: state_d = ST_MUL;
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = last_term ? ST_FIN1 : ST_OPER;
        end
      end
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = (state_q == ST_IDLE);
    cfg_i.ready      = 1'b1;
    div_ctrl.start   = (state_q == ST_LOAD);
    div_ctrl.divisor = d_q;
    out_load         = (state_q == ST_FIN2) && (!out_valid_q || out_o.ready);
  end

  always_comb begin
    g_sel = g_q[2'(idx_q - IDX_G0)];
    priority if (idx_q == IDX_SUM) begin
      x_sel = 33'(fl_q) + 33'(fr_q);
    end else if (idx_q == IDX_DIFF) begin
      x_sel = 33'(fr_q) - 33'(fl_q);
    end else begin
      x_sel = 33'(g_sel);
    end
  end

  assign mul_res  = 63'(w_q) * 63'(mag_q[31:0]);
  assign rounded  = prod_q + (PROD_W'(d_q) << (FracBits - 1));
  assign q_ext    = 64'(quotient);
  assign term     = neg_q ? -q_ext : q_ext;
  assign slot_sum = 64'(slot_q[0]) + 64'(slot_q[1]) + 64'(slot_q[2]) + 64'(slot_q[3]);

  ppbi_cdiv #(
    .FracBits (FracBits)
  ) u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (rounded[PROD_W-1:FracBits]),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_count_q <= '0;
      running_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        term_count_q <= cfg_i.data;
      end
      if (state_q == ST_FIN1) begin
        running_q <= sat32(acc_int_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q       <= r_new;
      idx_q     <= IDX_SUM;
      w_q       <= in_i.data.interval_width;
      fl_q      <= in_i.data.f_left;
      fr_q      <= in_i.data.f_right;
      g_q[0]    <= in_i.data.coef_0;
      g_q[1]    <= in_i.data.coef_1;
      g_q[2]    <= in_i.data.coef_2;
      g_q[3]    <= in_i.data.coef_3;
      acc_int_q <= in_i.data.restart ? 64'sd0 : 64'(running_q);
      acc_s1_q  <= '0;
      slot_q[1] <= '0;
      slot_q[2] <= '0;
      slot_q[3] <= '0;
    end
    if (state_q == ST_OPER) begin
      neg_q <= x_sel[32];
      mag_q <= x_sel[32] ? 33'(-x_sel) : 33'(x_sel);
      d_q   <= (idx_q < IDX_G0) ? TRAP_DIV : idx_q;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mag_q[32] ? {1'b0, w_q, 32'd0} : {1'b0, mul_res};
    end
    if (state_q == ST_DIV && div_done) begin
      idx_q <= idx_q + 3'd1;
      if (idx_q == IDX_SUM) begin
        acc_int_q <= acc_int_q + term;
      end else if (idx_q == IDX_DIFF) begin
        acc_s1_q <= acc_s1_q - term;
      end else begin
        acc_int_q <= acc_int_q + term;
        if (idx_q == IDX_G0) begin
          acc_s1_q <= acc_s1_q - term;
        end else begin
          slot_q[2'(idx_q - IDX_G0)] <= sat32(-term);
        end
      end
    end
    if (state_q == ST_FIN1) begin
      slot_q[0] <= sat32(acc_s1_q);
    end
    if (out_load) begin
      out_q.integral_left <= running_q;
      out_q.slot_0        <= sat32(-slot_sum);
      out_q.slot_1        <= slot_q[0];
      out_q.slot_2        <= slot_q[1];
      out_q.slot_3        <= slot_q[2];
      out_q.slot_4        <= slot_q[3];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> rtl/ppbi_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the backward integral core
// Watches the input and output channels and checks ordering over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ppbi_checker import ppbi_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_data_i
);

  `PPBI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result beat changed")
  `PPBI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "input taken while an interval is in work")
  `PPBI_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_i, !$rose(out_valid_i), "result beat appeared right after input beat")
  `PPBI_ASSERT_NOW(a_result_from_work, $rose(out_valid_i), !$past(in_ready_i), "result beat appeared while idle")

endmodule

bind piecewise_poly_backward_integral_core ppbi_checker u_ppbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> tb/sv/piecewise_poly_backward_integral_core_test.sv
// ---------------------------------------------------------------------------
// Piecewise polynomial backward integral core testbench
// Sends interval beats to the core and checks every result beat field by
// field. Expected values come from a table of directed cases and from a
// behavioral predictor that tracks the running integral and the term count.
// The run covers every term count setting, random sender gaps and receiver
// stalls, and one long receiver hold that backs the core up.
// ---------------------------------------------------------------------------
module piecewise_poly_backward_integral_core_test;
  import ppbi_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned NUM_CASES       = 23;
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [30:0] W_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] W_ONE = 31'h0001_0000;

  typedef struct {
    term_count_t tc;
    in_beat_t    beat;
    bit          typed;
    out_beat_t   want;
  } interval_case_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ppbi_cfg_if cfg_bus ();
  ppbi_in_if  in_bus ();
  ppbi_out_if out_bus ();

  piecewise_poly_backward_integral_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  out_beat_t          pending_results [$];
  logic signed [31:0] running_integral_q = '0;
  term_count_t        term_count_q       = '0;
  int unsigned        tx_idle_pct        = 0;
  int unsigned        rx_stall_pct       = 0;
  int unsigned        hold_requests      = 0;
  int unsigned        mismatch_count     = 0;
  int unsigned        cycle_count        = 0;

  string field_names [6] = '{"integral_left", "slot_0", "slot_1", "slot_2", "slot_3",
                             "slot_4"};

  interval_case_t directed_cases [NUM_CASES] = '{
    '{3'd0, in_beat_t'{1'b1, 31'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN},
      1'b1, out_beat_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b1, W_ONE, Q_ONE, Q_ONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      1'b1, out_beat_t'{Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b0, W_ONE, 32'h0002_0000, 32'h0, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      1'b1, out_beat_t'{32'h0002_0000, 32'hFFFF_0000, Q_ONE, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b1, W_MAX, Q_MAX, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, out_beat_t'{Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b0, W_MAX, Q_MAX, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, '0},
    '{3'd0, in_beat_t'{1'b1, W_MAX, Q_MIN, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, out_beat_t'{Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b0, W_MAX, Q_MIN, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, out_beat_t'{Q_MIN, Q_MAX, Q_MIN, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b1, 31'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, out_beat_t'{32'h1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0}},
    '{3'd0, in_beat_t'{1'b1, 31'd1, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, out_beat_t'{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}},
    '{3'd1, in_beat_t'{1'b1, W_ONE, 32'h0, 32'h0, 32'h0002_0000, Q_MAX, Q_MAX, Q_MAX},
      1'b0, '0},
    '{3'd1, in_beat_t'{1'b0, 31'h0001_8000, Q_ONE, 32'hFFFE_0000, 32'hFFFF_8000,
                       32'h0000_0123, 32'h0, 32'h0},
      1'b0, '0},
    '{3'd2, in_beat_t'{1'b1, W_ONE, Q_ONE, 32'h0, Q_ONE, Q_ONE, Q_ONE, Q_ONE},
      1'b0, '0},
    '{3'd2, in_beat_t'{1'b0, 31'h0002_AAAA, 32'h7FFF_0000, 32'hFFFF_FFFF, Q_MIN, Q_MAX,
                       32'h0, 32'h0},
      1'b0, '0},
    '{3'd3, in_beat_t'{1'b1, W_ONE, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE, Q_ONE},
      1'b0, '0},
    '{3'd4, in_beat_t'{1'b1, 31'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      1'b1, out_beat_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{3'd4, in_beat_t'{1'b1, W_ONE, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE, Q_ONE},
      1'b0, '0},
    '{3'd4, in_beat_t'{1'b0, W_MAX, 32'h0, 32'h0, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      1'b0, '0},
    '{3'd4, in_beat_t'{1'b0, W_MAX, 32'h0, 32'h0, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
      1'b0, '0},
    '{3'd4, in_beat_t'{1'b1, 31'd3, 32'h0, 32'h0, Q_ONE, Q_MIN, Q_ONE, 32'hFFFF_0000},
      1'b0, '0},
    '{3'd7, in_beat_t'{1'b1, W_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE},
      1'b0, '0},
    '{3'd7, in_beat_t'{1'b0, 31'h0000_8000, 32'hFFF0_0000, 32'h0010_0000, 32'h0005_5555,
                       32'h000A_AAAA, Q_MIN, Q_MAX},
      1'b0, '0},
    '{3'd5, in_beat_t'{1'b0, W_ONE, 32'h0, 32'h0, Q_ONE, 32'h0, 32'h0, Q_ONE},
      1'b0, '0},
    '{3'd6, in_beat_t'{1'b1, W_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, Q_MAX},
      1'b0, '0}
  };

  // Rounds w * x / d to the nearest fixed-point value, ties away from zero.
  function automatic longint scaled_term(input logic [30:0] w, input longint x,
                                         input int unsigned d);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned div;
    longint unsigned q;
    mag  = (x < 0) ? longint'(-x) : longint'(x);
    prod = longint'({33'd0, w}) * mag;
    div  = longint'(d) << FRAC_BITS;
    q    = (prod + div / 2) / div;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_beat_t integrate_interval(input in_beat_t b);
    longint             coef [4];
    longint             fl;
    longint             fr;
    longint             sum;
    int unsigned        terms;
    int unsigned        top;
    int unsigned        k;
    logic signed [31:0] slot [5];
    out_beat_t          r;
    fl      = longint'($signed(b.f_left));
    fr      = longint'($signed(b.f_right));
    coef[0] = longint'($signed(b.coef_0));
    coef[1] = longint'($signed(b.coef_1));
    coef[2] = longint'($signed(b.coef_2));
    coef[3] = longint'($signed(b.coef_3));
    terms   = (term_count_q > TERM_LIMIT) ? TERM_LIMIT : int'(term_count_q);
    top     = (terms > 1) ? terms : 1;

    sum = b.restart ? 64'sd0 : longint'(running_integral_q);
    sum += scaled_term(b.interval_width, fl + fr, 2);
    for (k = 0; k < terms; k++) begin
      sum += scaled_term(b.interval_width, coef[k], k + 2);
    end
    running_integral_q = clamp_q16(sum);

    for (k = 0; k < 5; k++) begin
      slot[k] = '0;
    end
    sum = -scaled_term(b.interval_width, fr - fl, 2);
    if (terms > 0) begin
      sum -= scaled_term(b.interval_width, coef[0], 2);
    end
    slot[1] = clamp_q16(sum);
    for (k = 2; k <= top; k++) begin
      slot[k] = clamp_q16(-scaled_term(b.interval_width, coef[k - 1], k + 1));
    end
    sum = 0;
    for (k = 1; k < 5; k++) begin
      sum -= longint'(slot[k]);
    end
    slot[0] = clamp_q16(sum);

    r.integral_left = running_integral_q;
    r.slot_0        = slot[0];
    r.slot_1        = slot[1];
    r.slot_2        = slot[2];
    r.slot_3        = slot[3];
    r.slot_4        = slot[4];
    return r;
  endfunction

  function automatic logic [31:0] random_q16();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          default: v = Q_ONE;
        endcase
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  function automatic in_beat_t random_interval();
    in_beat_t    b;
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 4))
      0:       b.interval_width = raw[30:0];
      1:       b.interval_width = 31'($urandom_range(0, 32'h4_0000));
      2:       b.interval_width = ($urandom_range(0, 1) == 0) ? 31'd1 : W_MAX;
      default: b.interval_width = 31'($urandom_range(0, 32'hF_FFFF));
    endcase
    b.restart = ($urandom_range(0, 7) == 0);
    b.f_left  = random_q16();
    b.f_right = random_q16();
    b.coef_0  = random_q16();
    b.coef_1  = random_q16();
    b.coef_2  = random_q16();
    b.coef_3  = random_q16();
    return b;
  endfunction

  task automatic send_interval(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= b;
    @(posedge clk_i);
    while (!in_bus.ready) begin
      @(posedge clk_i);
    end
    predicted = integrate_interval(b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic set_term_count(input term_count_t value);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) begin
      @(posedge clk_i);
    end
    cfg_bus.valid <= 1'b0;
    term_count_q = value;
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t   want;
    logic [31:0] exp_field;
    logic [31:0] got_field;
    int          i;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("unexpected result beat %h", got);
      end
      return;
    end
    want = pending_results.pop_front();
    for (i = 0; i < 6; i++) begin
      exp_field = want[191 - 32 * i -: 32];
      got_field = got[191 - 32 * i -: 32];
      if (exp_field !== got_field) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%s mismatch: expected %h, got %h", field_names[i], exp_field,
                   got_field);
        end
      end
    end
  endtask

  // The receiver also serves long hold requests, counted here in cycles.
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        check_result(out_bus.data);
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("piecewise_poly_backward_integral_core test failed");
      $finish;
    end
  end

  initial begin
    term_count_t phase_tc [8];
    int          p;
    int          n;
    phase_tc = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6};
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NUM_CASES; n++) begin
      if (directed_cases[n].tc != term_count_q) begin
        set_term_count(directed_cases[n].tc);
      end
      send_interval(directed_cases[n].beat, directed_cases[n].typed,
                    directed_cases[n].want);
    end

    for (p = 0; p < 8; p++) begin
      set_term_count(phase_tc[p]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 85;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 85;
        end
        default: begin
          tx_idle_pct  = 10;
          rx_stall_pct = 10;
        end
      endcase
      if (p == 4) begin
        hold_requests++;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_interval(random_interval(), 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("piecewise_poly_backward_integral_core test passed");
    end else begin
      $display("piecewise_poly_backward_integral_core test failed");
    end
    $finish;
  end

endmodule
